@@ hdl/sorted_multiset_merge_ops_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted multiset merge: assertion macros
// Concurrent assertion wrappers, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_MERGE_OPS_DEFINES_SVH
`define SORTED_MULTISET_MERGE_OPS_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SMM_ASSERT_NR(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMM_ASSERT(label, prop, msg)
`define SMM_ASSERT_NR(label, prop, msg)
`endif
`endif

@@ hdl/smm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted multiset merge: package
// Shared widths, command, status and mode codes, and the command and result item types.
// ----------------------------------------------------------------------------
`default_nettype none
package smm_pkg;
	localparam int SET_DEPTH_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int VAL_W = 32;
	localparam int RCNT_W = 17;

	localparam logic [1:0] CMD_ADD_A = 2'd0;
	localparam logic [1:0] CMD_ADD_B = 2'd1;
	localparam logic [1:0] CMD_EMIT  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [2:0] ST_NEW  = 3'd0;
	localparam logic [2:0] ST_RAISE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_SAT  = 3'd3;
	localparam logic [2:0] ST_MERGE = 3'd4;

	localparam logic [1:0] MODE_UNION = 2'd0;
	localparam logic [1:0] MODE_INTER = 2'd1;
	localparam logic [1:0] MODE_SYMDIFF = 2'd2;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [VAL_W-1:0] val;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [VAL_W-1:0]  value;
		logic [RCNT_W-1:0] count;
		logic              empty;
		logic              last;
	} res_item_t;
endpackage
`default_nettype wire

@@ hdl/smm_fifo.sv @@
// ----------------------------------------------------------------------------
// Sorted multiset merge: item queue
// Small register queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
`default_nettype none
module smm_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         rd,
	output logic              empty,
	output logic [W-1:0]      rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule
`default_nettype wire

@@ hdl/smm_back.sv @@
// ----------------------------------------------------------------------------
// Sorted multiset merge: execution unit
// Holds both sorted tables, performs inserts by parallel compare and shift and streams merges.
// ----------------------------------------------------------------------------
`default_nettype none
module smm_back #(
	parameter int SET_DEPTH = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [1:0]          mode,
	input  wire logic                cmd_valid,
	input  wire smm_pkg::cmd_item_t  cmd_in,
	output logic                     cmd_take,
	output logic                     res_push,
	output smm_pkg::res_item_t       res_out,
	input  wire logic                res_full
);
	import smm_pkg::*;
	localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int FW = $clog2(SET_DEPTH + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MERGE = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [VAL_W-1:0] a_val_q [SET_DEPTH];
	logic [COUNT_BITS-1:0] a_cnt_q [SET_DEPTH];
	logic [VAL_W-1:0] b_val_q [SET_DEPTH];
	logic [COUNT_BITS-1:0] b_cnt_q [SET_DEPTH];
	logic [FW-1:0] a_fill_q, b_fill_q;

	logic [1:0] state_q;
	logic [FW-1:0] i_q, j_q;
	// merged item held back until it is known whether it is the final one
	logic pend_q;
	logic [VAL_W-1:0] pend_val_q;
	logic [RCNT_W-1:0] pend_cnt_q;

	// insert path
	logic is_b;
	logic [VAL_W-1:0] sv [SET_DEPTH];
	logic [COUNT_BITS-1:0] sc [SET_DEPTH];
	logic [FW-1:0] sfill;
	logic [SET_DEPTH-1:0] lt, eq;
	logic hit, isfull;
	logic [IW-1:0] hit_idx;
	logic [COUNT_BITS-1:0] hit_cnt;

	always_comb begin
		is_b = cmd_in.cmd == CMD_ADD_B;
		sfill = is_b ? b_fill_q : a_fill_q;
		hit = 1'b0;
		hit_idx = '0;
		for (int k = 0; k < SET_DEPTH; k++) begin
			sv[k] = is_b ? b_val_q[k] : a_val_q[k];
			sc[k] = is_b ? b_cnt_q[k] : a_cnt_q[k];
			lt[k] = (FW'(k) < sfill) && ($signed(sv[k]) < $signed(cmd_in.val));
			eq[k] = (FW'(k) < sfill) && (sv[k] == cmd_in.val);
			if (eq[k]) begin
				hit = 1'b1;
				hit_idx = IW'(k);
			end
		end
		hit_cnt = sc[hit_idx];
		isfull = sfill == FW'(SET_DEPTH);
	end

	// merge path
	logic a_ok, b_ok, ta, tb;
	logic [VAL_W-1:0] va, vb;
	logic [COUNT_BITS-1:0] ca, cb;
	logic [RCNT_W-1:0] mcnt;
	logic memit, mdone;
	logic [FW-1:0] i_n, j_n;

	always_comb begin
		a_ok = i_q < a_fill_q;
		b_ok = j_q < b_fill_q;
		va = a_val_q[i_q[IW-1:0]];
		vb = b_val_q[j_q[IW-1:0]];
		ca = a_cnt_q[i_q[IW-1:0]];
		cb = b_cnt_q[j_q[IW-1:0]];
		if (a_ok && b_ok) begin
			ta = $signed(va) <= $signed(vb);
			tb = $signed(vb) <= $signed(va);
		end else begin
			ta = a_ok;
			tb = !a_ok;
		end
		memit = 1'b0;
		mcnt = '0;
		if (ta && tb) begin
			if (mode == MODE_UNION) begin
				memit = 1'b1;
				mcnt = RCNT_W'(ca) + RCNT_W'(cb);
			end else if (mode == MODE_INTER) begin
				memit = 1'b1;
				mcnt = RCNT_W'((ca <= cb) ? ca : cb);
			end else begin
				memit = ca != cb;
				mcnt = RCNT_W'((ca > cb) ? ca - cb : cb - ca);
			end
		end else if (ta) begin
			memit = mode != MODE_INTER;
			mcnt = RCNT_W'(ca);
		end else begin
			memit = mode != MODE_INTER;
			mcnt = RCNT_W'(cb);
		end
		i_n = ta ? i_q + 1'b1 : i_q;
		j_n = tb ? j_q + 1'b1 : j_q;
		mdone = !((i_n < a_fill_q) || (j_n < b_fill_q));
	end

	logic idle_go, is_add;
	assign is_add = cmd_in.cmd == CMD_ADD_A || cmd_in.cmd == CMD_ADD_B;
	assign idle_go = (state_q == S_IDLE) && cmd_valid && !res_full;
	assign cmd_take = idle_go;

	// at most one item per cycle into the result queue, none while it is full
	always_comb begin
		res_push = 1'b0;
		res_out = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!res_full && cmd_valid && is_add) begin
					res_push = 1'b1;
					res_out.value = cmd_in.val;
					res_out.last = 1'b1;
					if (hit) begin
						res_out.status = (hit_cnt == CMAX) ? ST_SAT : ST_RAISE;
						res_out.count = (hit_cnt == CMAX) ? RCNT_W'(hit_cnt)
							: RCNT_W'(hit_cnt) + 1'b1;
					end else if (isfull) begin
						res_out.status = ST_FULL;
					end else begin
						res_out.status = ST_NEW;
						res_out.count = RCNT_W'(1);
					end
				end
			end
			S_MERGE: begin
				if (!res_full) begin
					res_push = memit && pend_q;
					res_out.status = ST_MERGE;
					res_out.value = pend_val_q;
					res_out.count = pend_cnt_q;
				end
			end
			S_FLUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					res_out.status = ST_MERGE;
					res_out.value = pend_q ? pend_val_q : '0;
					res_out.count = pend_q ? pend_cnt_q : '0;
					res_out.empty = !pend_q;
					res_out.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// table storage, written in place with shift on insert
	always_ff @(posedge clk) begin
		if (idle_go && is_add) begin
			for (int k = 0; k < SET_DEPTH; k++) begin
				if (hit) begin
					if (eq[k] && sc[k] != CMAX) begin
						if (is_b) b_cnt_q[k] <= sc[k] + 1'b1;
						else a_cnt_q[k] <= sc[k] + 1'b1;
					end
				end else if (!isfull && !lt[k] && FW'(k) <= sfill) begin
					if (k > 0 && lt[k-1]) begin
						if (is_b) begin
							b_val_q[k] <= cmd_in.val; b_cnt_q[k] <= COUNT_BITS'(1);
						end else begin
							a_val_q[k] <= cmd_in.val; a_cnt_q[k] <= COUNT_BITS'(1);
						end
					end else if (k == 0) begin
						if (is_b) begin
							b_val_q[k] <= cmd_in.val; b_cnt_q[k] <= COUNT_BITS'(1);
						end else begin
							a_val_q[k] <= cmd_in.val; a_cnt_q[k] <= COUNT_BITS'(1);
						end
					end else begin
						if (is_b) begin
							b_val_q[k] <= sv[k-1]; b_cnt_q[k] <= sc[k-1];
						end else begin
							a_val_q[k] <= sv[k-1]; a_cnt_q[k] <= sc[k-1];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_fill_q <= '0;
			b_fill_q <= '0;
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			pend_q <= 1'b0;
			pend_val_q <= '0;
			pend_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_MERGE: begin
					if (!res_full) begin
						i_q <= i_n;
						j_q <= j_n;
						if (memit) begin
							pend_q <= 1'b1;
							pend_val_q <= ta ? va : vb;
							pend_cnt_q <= mcnt;
						end
						if (mdone) state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!res_full) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (idle_go) begin
						unique case (cmd_in.cmd)
							CMD_CLEAR: begin
								a_fill_q <= '0;
								b_fill_q <= '0;
							end
							CMD_EMIT: begin
								i_q <= '0;
								j_q <= '0;
								pend_q <= 1'b0;
								state_q <= (a_fill_q == '0 && b_fill_q == '0) ? S_FLUSH
									: S_MERGE;
							end
							default: begin
								if (!hit && !isfull) begin
									if (is_b) b_fill_q <= b_fill_q + 1'b1;
									else a_fill_q <= a_fill_q + 1'b1;
								end
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/sorted_multiset_merge_ops.sv @@
`include "sorted_multiset_merge_ops_defines.svh"
// ----------------------------------------------------------------------------
// Sorted multiset merge
// Two sorted multisets with add, clear and merge (union, intersection,
// symmetric difference) commands.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue; the execution unit takes the head
// item when idle and the result queue is not full. An add is done in the
// cycle it is taken by a parallel compare and shift; its result goes into the
// result queue and from there to the result ports. A clear gives no result.
// An emit holds the execution unit for one merge step per cycle while the
// result queue has room (fillA + fillB steps at most) and a closing state that
// releases the final item; the command queue meanwhile accepts items until full.
// Results leave via a four-entry queue; a full one stalls the execution unit.
`default_nettype none
module sorted_multiset_merge_ops #(
	parameter int SET_DEPTH = smm_pkg::SET_DEPTH_DEF,
	parameter int COUNT_BITS = smm_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] value,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       status,
	output logic [31:0]      result_value,
	output logic [16:0]      result_count,
	output logic             empty_res,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata
);
	import smm_pkg::*;
	localparam int CW = $bits(cmd_item_t);
	localparam int RW = $bits(res_item_t);

	logic [1:0] mode_q;
	cmd_item_t cin, cq;
	res_item_t rin, rq;
	logic cq_empty, take, rpush, rfull;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_SYMDIFF;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	assign cin.cmd = command;
	assign cin.val = value;

	smm_fifo #(.W(CW), .DEPTH(2)) u_cmdq (
		.clk, .arst_n, .wr(push), .wdata(cin), .full,
		.rd(take), .empty(cq_empty), .rdata(cq)
	);

	smm_back #(.SET_DEPTH(SET_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .mode(mode_q), .cmd_valid(!cq_empty), .cmd_in(cq),
		.cmd_take(take), .res_push(rpush), .res_out(rin), .res_full(rfull)
	);

	smm_fifo #(.W(RW), .DEPTH(4)) u_resq (
		.clk, .arst_n, .wr(rpush), .wdata(rin), .full(rfull),
		.rd(pop), .empty, .rdata(rq)
	);

	assign status = rq.status;
	assign result_value = rq.value;
	assign result_count = rq.count;
	assign empty_res = rq.empty;
	assign last = rq.last;

	`SMM_ASSERT(a_take_valid, take |-> !cq_empty, "command taken from empty queue")
	`SMM_ASSERT(a_push_room, rpush |-> !rfull, "result pushed into full queue")
	`SMM_ASSERT(a_empty_last, (!empty && empty_res) |-> last, "empty merge item not last")
endmodule
`default_nettype wire
